FILE: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL.
// Each macro expects a clock named clk and an active-low reset named rst_n.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define NSFC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define NSFC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/nsfc_pkg.sv
// ---------------------------------------------------------------------------
// nsfc_pkg
// Types, character codes and helper functions for the sentence framer.
// ---------------------------------------------------------------------------
package nsfc_pkg;

    localparam int HEAD_LEN   = 6;
    localparam int HEAD_KINDS = 5;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_NUL    = 8'h00;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NO_SUM   = 2'd1;
    localparam logic [1:0] STATUS_MISMATCH = 2'd2;

    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_RMC   = 2'd1;
    localparam logic [1:0] KIND_GGA   = 2'd2;
    localparam logic [1:0] KIND_GSV   = 2'd3;

    // Head patterns: 0 $GPRMC, 1 $GNRMC, 2 $GPGGA, 3 $GNGGA, 4 $GPGSV
    localparam logic [HEAD_KINDS-1:0] HEAD_ALL = '1;
    localparam logic [HEAD_KINDS-1:0] HEAD_RMC = 5'b00011;
    localparam logic [HEAD_KINDS-1:0] HEAD_GGA = 5'b01100;
    localparam logic [HEAD_KINDS-1:0] HEAD_GSV = 5'b10000;

    typedef struct packed {
        logic [1:0] status;
        logic [1:0] kind;
        logic [9:0] length;
        logic [7:0] computed;
        logic [7:0] received;
    } nsfc_result_t;

    // {is_digit, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h41 && c <= 8'h46)
            r = {1'b1, 4'(c - 8'h37)};
        else if (c >= 8'h61 && c <= 8'h66)
            r = {1'b1, 4'(c - 8'h57)};
        return r;
    endfunction

    // Expected character of head pattern k at position pos
    function automatic logic [7:0] head_char(input logic [2:0] k, input logic [2:0] pos);
        logic [7:0] r;
        case (pos)
            3'd0:    r = CHAR_DOLLAR;
            3'd1:    r = 8'h47;                                           // G
            3'd2:    r = (k == 3'd1 || k == 3'd3) ? 8'h4E : 8'h50;        // N / P
            3'd3:    r = (k < 3'd2) ? 8'h52 : 8'h47;                      // R / G
            3'd4:    r = (k < 3'd2) ? 8'h4D : ((k < 3'd4) ? 8'h47 : 8'h53); // M / G / S
            3'd5:    r = (k < 3'd2) ? 8'h43 : ((k < 3'd4) ? 8'h41 : 8'h56); // C / A / V
            default: r = CHAR_NUL;
        endcase
        return r;
    endfunction

endpackage

FILE: hw/rtl/nsfc_in_stage.sv
// ---------------------------------------------------------------------------
// nsfc_in_stage
// Input register: holds one received byte until the core takes it.
// ---------------------------------------------------------------------------
module nsfc_in_stage
    import nsfc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    input  logic       take,
    output logic       hold_valid,
    output logic [7:0] hold_byte
);

    logic       valid_reg;
    logic [7:0] byte_reg;

    assign in_ready   = !valid_reg || take;
    assign hold_valid = valid_reg;
    assign hold_byte  = byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= rx_byte;
        end
    end

endmodule

FILE: hw/rtl/nsfc_frame_core.sv
// ---------------------------------------------------------------------------
// nsfc_frame_core
// Per-byte framing state, running XOR, hex field parse and head match.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module nsfc_frame_core
    import nsfc_pkg::*;
#(
    parameter int BUF_BYTES = 128
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         hold_valid,
    input  logic [7:0]   hold_byte,
    input  logic         out_free,
    output logic         take,
    output logic         load,
    output nsfc_result_t result
);

    localparam int FILL_W = $clog2(BUF_BYTES + 1);
    localparam int EXT_W  = (FILL_W > 10) ? FILL_W : 10;

    logic                  capturing_reg, capturing_next;
    logic [FILL_W-1:0]     fill_reg, fill_next;
    logic [7:0]            xor_reg, xor_next;
    logic                  star_reg, star_next;
    logic                  hex_open_reg, hex_open_next;
    logic [7:0]            hex_reg, hex_next;
    logic                  too_big_reg, too_big_next;
    logic                  ended_reg, ended_next;
    logic [HEAD_KINDS-1:0] head_reg, head_next;

    logic              buf_full;
    logic              emit;
    logic [7:0]        head_eff;
    logic [4:0]        digit;
    logic [EXT_W-1:0]  fill_ext;

    assign buf_full = (fill_reg >= FILL_W'(BUF_BYTES));
    assign digit    = hex_digit(hold_byte);
    assign head_eff = (star_reg || ended_reg) ? CHAR_NUL : hold_byte;
    assign fill_ext = EXT_W'(fill_reg);

    always_comb
    begin
        capturing_next = capturing_reg;
        fill_next      = fill_reg;
        xor_next       = xor_reg;
        star_next      = star_reg;
        hex_open_next  = hex_open_reg;
        hex_next       = hex_reg;
        too_big_next   = too_big_reg;
        ended_next     = ended_reg;
        head_next      = head_reg;
        emit           = 1'b0;

        // Drop an overlong capture before looking at the byte
        if (buf_full)
        begin
            capturing_next = 1'b0;
            fill_next      = '0;
            xor_next       = '0;
            star_next      = 1'b0;
            hex_open_next  = 1'b0;
            hex_next       = '0;
            too_big_next   = 1'b0;
            ended_next     = 1'b0;
            head_next      = HEAD_ALL;
        end

        if (hold_byte == CHAR_DOLLAR)
        begin
            capturing_next = 1'b1;
            fill_next      = FILL_W'(1);
            xor_next       = '0;
            star_next      = 1'b0;
            hex_open_next  = 1'b0;
            hex_next       = '0;
            too_big_next   = 1'b0;
            ended_next     = 1'b0;
            head_next      = HEAD_ALL;
        end
        else if (capturing_next)
        begin
            if (hold_byte == CHAR_CR || hold_byte == CHAR_LF)
            begin
                emit           = 1'b1;
                capturing_next = 1'b0;
                fill_next      = '0;
                xor_next       = '0;
                star_next      = 1'b0;
                hex_open_next  = 1'b0;
                hex_next       = '0;
                too_big_next   = 1'b0;
                ended_next     = 1'b0;
                head_next      = HEAD_ALL;
            end
            else
            begin
                if (fill_reg < FILL_W'(HEAD_LEN))
                begin
                    for (int k = 0; k < HEAD_KINDS; k++)
                    begin
                        if (head_char(3'(k), fill_reg[2:0]) != head_eff)
                            head_next[k] = 1'b0;
                    end
                end
                if (!ended_reg)
                begin
                    if (hold_byte == CHAR_NUL)
                    begin
                        ended_next    = 1'b1;
                        hex_open_next = 1'b0;
                    end
                    else if (!star_reg)
                    begin
                        if (hold_byte == CHAR_STAR)
                        begin
                            star_next     = 1'b1;
                            hex_open_next = 1'b1;
                        end
                        else
                        begin
                            xor_next = xor_reg ^ hold_byte;
                        end
                    end
                    else if (hex_open_reg)
                    begin
                        if (digit[4])
                        begin
                            if (hex_reg[7:4] != 4'd0)
                                too_big_next = 1'b1;
                            hex_next = {hex_reg[3:0], digit[3:0]};
                        end
                        else
                        begin
                            hex_open_next = 1'b0;
                        end
                    end
                end
                fill_next = fill_reg + FILL_W'(1);
            end
        end
    end

    // Result fields come from the state held before the terminator
    always_comb
    begin
        result.computed = xor_reg;
        result.received = hex_reg;
        result.length   = fill_ext[9:0];
        result.kind     = KIND_OTHER;
        if (!star_reg)
            result.status = STATUS_NO_SUM;
        else if (too_big_reg || hex_reg != xor_reg)
            result.status = STATUS_MISMATCH;
        else
            result.status = STATUS_OK;
        if (result.status == STATUS_OK && fill_reg >= FILL_W'(HEAD_LEN))
        begin
            if ((head_reg & HEAD_RMC) != '0)
                result.kind = KIND_RMC;
            else if ((head_reg & HEAD_GGA) != '0)
                result.kind = KIND_GGA;
            else if ((head_reg & HEAD_GSV) != '0)
                result.kind = KIND_GSV;
        end
    end

    // Stall only a terminator that finds the result register occupied
    assign take = hold_valid && (!emit || out_free);
    assign load = hold_valid && emit && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capturing_reg <= 1'b0;
            fill_reg      <= '0;
            xor_reg       <= '0;
            star_reg      <= 1'b0;
            hex_open_reg  <= 1'b0;
            hex_reg       <= '0;
            too_big_reg   <= 1'b0;
            ended_reg     <= 1'b0;
            head_reg      <= HEAD_ALL;
        end
        else if (take)
        begin
            capturing_reg <= capturing_next;
            fill_reg      <= fill_next;
            xor_reg       <= xor_next;
            star_reg      <= star_next;
            hex_open_reg  <= hex_open_next;
            hex_reg       <= hex_next;
            too_big_reg   <= too_big_next;
            ended_reg     <= ended_next;
            head_reg      <= head_next;
        end
    end

    `NSFC_ASSERT_IMP(a_idle_empty, !capturing_reg, fill_reg == '0 && !star_reg, "idle with frame state")
    `NSFC_ASSERT_IMP(a_hex_after_star, hex_open_reg, star_reg && !ended_reg, "hex field open without star")
    `NSFC_ASSERT_NXT(a_emit_closes, load, !capturing_reg, "capture still open after result")

endmodule

FILE: hw/rtl/nsfc_out_stage.sv
// ---------------------------------------------------------------------------
// nsfc_out_stage
// Result register: holds one status transaction until it is taken.
// ---------------------------------------------------------------------------
module nsfc_out_stage
    import nsfc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  nsfc_result_t result,
    output logic         out_free,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [1:0]   status,
    output logic [1:0]   sentence_kind,
    output logic [9:0]   text_length,
    output logic [7:0]   computed_sum,
    output logic [7:0]   received_sum
);

    logic         valid_reg;
    nsfc_result_t res_reg;

    assign out_free      = !valid_reg || out_ready;
    assign out_valid     = valid_reg;
    assign status        = res_reg.status;
    assign sentence_kind = res_reg.kind;
    assign text_length   = res_reg.length;
    assign computed_sum  = res_reg.computed;
    assign received_sum  = res_reg.received;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= result;
        end
    end

endmodule

FILE: hw/rtl/nmea_sentence_framer_checker.sv
// Status path: CR/LF byte -> input register -> result register -> out_valid.
// Throughput: one byte per cycle unless stalled; per-byte update is one registered step.
// Only a terminator meeting a full, unread result register stalls the input.
// Reset (rst_n low, asynchronous): capture idle, frame state cleared, no result pending.
// ---------------------------------------------------------------------------
// nmea_sentence_framer_checker
// Frames '$'...CR/LF sentences from a byte stream and checks the XOR sum.
// ---------------------------------------------------------------------------
module nmea_sentence_framer_checker
    import nsfc_pkg::*;
#(
    parameter int BUF_BYTES = 128
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] status,
    output logic [1:0] sentence_kind,
    output logic [9:0] text_length,
    output logic [7:0] computed_sum,
    output logic [7:0] received_sum
);

    // Byte held in the input register, waiting for the core
    logic         hold_valid;
    logic [7:0]   hold_byte;

    // Core handshake: take advances the input register, load fills the result register
    logic         take;
    logic         load;
    logic         out_free;
    nsfc_result_t result;

    // Input register: decouple the byte stream from the core
    nsfc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .take       (take),
        .hold_valid (hold_valid),
        .hold_byte  (hold_byte)
    );

    // Framing core: advance the sentence state one byte per cycle unless stalled, and
    // build the status transaction when a terminator closes a capture
    nsfc_frame_core #(
        .BUF_BYTES (BUF_BYTES)
    ) u_frame_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .hold_valid (hold_valid),
        .hold_byte  (hold_byte),
        .out_free   (out_free),
        .take       (take),
        .load       (load),
        .result     (result)
    );

    // Result register: hold the status transaction until the consumer takes it
    nsfc_out_stage u_out_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (load),
        .result        (result),
        .out_free      (out_free),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .sentence_kind (sentence_kind),
        .text_length   (text_length),
        .computed_sum  (computed_sum),
        .received_sum  (received_sum)
    );

endmodule

FILE: tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: NMEA sentence framer and checksum checker regression
// Streams bytes into the framer through a valid/ready channel and predicts
// each sentence report (status, kind, length, both sums) from the bytes
// taken. Directed sentences come first, then random well-formed sentences
// with broken ones, noise, overflowing lines and back-pressure mixed in.
// ---------------------------------------------------------------------------
import nsfc_pkg::*;

class sentence_scoreboard;

    int unsigned    frame_cap;
    // framing state of the predicted block
    bit             capturing;
    int unsigned    fill;
    logic [7:0]     xor_acc;
    bit             star_seen;
    bit             hex_open;
    logic [7:0]     hex_val;
    bit             hex_too_big;
    bit             text_ended;
    logic [HEAD_KINDS-1:0] head_bits;
    logic [8*HEAD_LEN-1:0] heads[HEAD_KINDS];

    nsfc_result_t   due_reports[$];
    int unsigned    produced;
    int unsigned    checked;
    int unsigned    drops;
    int unsigned    errors;
    int unsigned    kind_hits[4];
    int unsigned    status_hits[3];

    function new(int unsigned cap);
        frame_cap = cap;
        heads[0]  = "$GPRMC";
        heads[1]  = "$GNRMC";
        heads[2]  = "$GPGGA";
        heads[3]  = "$GNGGA";
        heads[4]  = "$GPGSV";
        capturing = 1'b0;
        clear_frame();
    endfunction

    function void clear_frame();
        fill        = 0;
        xor_acc     = '0;
        star_seen   = 1'b0;
        hex_open    = 1'b0;
        hex_val     = '0;
        hex_too_big = 1'b0;
        text_ended  = 1'b0;
        head_bits   = HEAD_ALL;
    endfunction

    // Advance the prediction by one accepted byte.
    function void note_byte(logic [7:0] c);
        nsfc_result_t r;
        logic [7:0]   eff;
        logic [3:0]   nib;
        int           shift;
        if (fill >= frame_cap)
        begin
            capturing = 1'b0;
            clear_frame();
            drops++;
        end
        if (c == CHAR_DOLLAR)
        begin
            capturing = 1'b1;
            clear_frame();
            fill = 1;
            return;
        end
        if (!capturing)
            return;
        if (c == CHAR_CR || c == CHAR_LF)
        begin
            if (!star_seen)
                r.status = STATUS_NO_SUM;
            else if (hex_too_big || hex_val != xor_acc)
                r.status = STATUS_MISMATCH;
            else
                r.status = STATUS_OK;
            r.kind = KIND_OTHER;
            if (r.status == STATUS_OK && fill >= HEAD_LEN)
            begin
                if (|(head_bits & HEAD_RMC))
                    r.kind = KIND_RMC;
                else if (|(head_bits & HEAD_GGA))
                    r.kind = KIND_GGA;
                else if (|(head_bits & HEAD_GSV))
                    r.kind = KIND_GSV;
            end
            r.length   = 10'(fill);
            r.computed = xor_acc;
            r.received = hex_val;
            due_reports.insert(due_reports.size(), r);
            produced++;
            capturing = 1'b0;
            clear_frame();
            return;
        end
        if (fill < HEAD_LEN)
        begin
            eff   = (star_seen || text_ended) ? CHAR_NUL : c;
            shift = 8 * (HEAD_LEN - 1 - int'(fill));
            for (int k = 0; k < HEAD_KINDS; k++)
                if (heads[k][shift +: 8] != eff)
                    head_bits[k] = 1'b0;
        end
        if (!text_ended)
        begin
            if (c == CHAR_NUL)
            begin
                text_ended = 1'b1;
                hex_open   = 1'b0;
            end
            else if (!star_seen)
            begin
                if (c == CHAR_STAR)
                begin
                    star_seen = 1'b1;
                    hex_open  = 1'b1;
                end
                else
                    xor_acc ^= c;
            end
            else if (hex_open)
            begin
                if ((c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f"))
                begin
                    nib = (c <= "9") ? c[3:0] : 4'(c[3:0] + 4'd9);
                    if (hex_val >= 8'd16)
                        hex_too_big = 1'b1;
                    hex_val = {hex_val[3:0], nib};
                end
                else
                    hex_open = 1'b0;
            end
        end
        fill++;
    endfunction

    // Compare one accepted report with the oldest prediction.
    function void check_report(nsfc_result_t got);
        nsfc_result_t want;
        if (due_reports.size() == 0)
        begin
            $error("report with nothing pending: status %0d length %0d", got.status,
                   got.length);
            errors++;
            return;
        end
        want = due_reports.pop_front();
        checked++;
        kind_hits[want.kind]++;
        status_hits[want.status]++;
        if (got.status !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
        end
        if (got.kind !== want.kind)
        begin
            $error("sentence_kind: expected %0d, got %0d", want.kind, got.kind);
            errors++;
        end
        if (got.length !== want.length)
        begin
            $error("text_length: expected %0d, got %0d", want.length, got.length);
            errors++;
        end
        if (got.computed !== want.computed)
        begin
            $error("computed_sum: expected %h, got %h", want.computed, got.computed);
            errors++;
        end
        if (got.received !== want.received)
        begin
            $error("received_sum: expected %h, got %h", want.received, got.received);
            errors++;
        end
    endfunction

endclass

module tb_top;

    localparam int          FRAME_CAP    = 128;
    localparam int          TARGET_BYTES = 600;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          DRAIN_CYCLES = 20;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] rx_byte;
    logic       out_valid;
    logic       out_ready;
    logic [1:0] status;
    logic [1:0] sentence_kind;
    logic [9:0] text_length;
    logic [7:0] computed_sum;
    logic [7:0] received_sum;

    sentence_scoreboard board = new(FRAME_CAP);

    // Shared knobs between the sender and the receiver
    bit          idle_on  = 1'b1;
    bit          hold_req = 1'b0;
    int unsigned bytes_sent;
    int unsigned cycle_count;
    int unsigned frame_idx;
    int unsigned long_sel;

    // Sentence under assembly, sent byte by byte by send_frame
    logic [7:0] frame_q[$];

    nmea_sentence_framer_checker #(
        .BUF_BYTES (FRAME_CAP)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .sentence_kind (sentence_kind),
        .text_length   (text_length),
        .computed_sum  (computed_sum),
        .received_sum  (received_sum)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog: end the run if the traffic never drains
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // Check every report transaction against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_report(nsfc_result_t'{status, sentence_kind, text_length,
                                              computed_sum, received_sum});
    end

    // Receiver: random stall bursts, plus one long hold-off
    // on request so that reports back up and the framer stalls its input.
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Append one byte to the sentence under assembly
    function automatic void put_byte(input logic [7:0] b);
        frame_q.insert(frame_q.size(), b);
    endfunction

    function automatic logic [7:0] hex_ascii(input logic [3:0] n, input bit lower);
        if (n < 4'd10)
            return 8'(8'h30 + n);
        return 8'((lower ? 8'h61 : 8'h41) + n - 8'd10);
    endfunction

    // Printable body character, never a dollar or a star
    function automatic logic [7:0] text_char();
        logic [7:0] c;
        c = 8'($urandom_range(8'h20, 8'h7E));
        if (c == CHAR_DOLLAR || c == CHAR_STAR)
            c = 8'h2C;
        return c;
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i]);
    endfunction

    // Append '*' and two hex digits of the sum since the last dollar, xor flip
    function automatic void seal_frame(input logic [7:0] flip, input bit lower);
        logic [7:0] sum;
        int         start;
        sum   = '0;
        start = 0;
        for (int i = frame_q.size() - 1; i >= 0; i--)
        begin
            if (frame_q[i] == CHAR_DOLLAR)
            begin
                start = i + 1;
                break;
            end
        end
        for (int i = start; i < frame_q.size(); i++)
            sum ^= frame_q[i];
        sum ^= flip;
        put_byte(CHAR_STAR);
        put_byte(hex_ascii(sum[7:4], lower));
        put_byte(hex_ascii(sum[3:0], lower));
    endfunction

    // Offer one byte; idle beforehand now and then, hold until taken.
    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_byte(b);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_q[i])
            send_byte(frame_q[i]);
        frame_q.delete();
    endtask

    task automatic release_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Line filling the capture buffer up to fill bytes, then an optional end
    task automatic long_frame(input int unsigned fill, input logic [7:0] term,
                              input bit has_term);
        add_text("$");
        repeat (fill - 4) put_byte(text_char());
        seal_frame(8'h00, 1'b0);
        if (has_term)
            put_byte(term);
        send_frame();
    endtask

    // Mostly well-formed sentences with random content; the rest are
    // broken sums, missing fields, abandoned lines and raw noise.
    task automatic random_frame();
        int unsigned mode;
        int unsigned pick;
        mode = $urandom_range(0, 99);
        // abandoned start, restarted by the real dollar
        if ($urandom_range(0, 9) == 0)
        begin
            add_text("$GP");
            repeat ($urandom_range(0, 3)) put_byte(text_char());
        end
        case ($urandom_range(0, 7))
            0:       add_text("$GPRMC");
            1:       add_text("$GNRMC");
            2:       add_text("$GPGGA");
            3:       add_text("$GNGGA");
            4:       add_text("$GPGSV");
            5:       add_text("$GN");
            default: add_text("$");
        endcase
        repeat ($urandom_range(0, 9))
        begin
            case ($urandom_range(0, 49))
                0:          put_byte(CHAR_NUL);
                1, 2, 3, 4: put_byte(8'($urandom_range(8'h80, 8'hFF)));
                default:    put_byte(text_char());
            endcase
        end
        if (mode < 60)
        begin
            seal_frame(8'h00, 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 4) == 0)
                put_byte(text_char());
        end
        else if (mode < 70)
            seal_frame(8'($urandom_range(1, 255)), 1'($urandom_range(0, 1)));
        else if (mode < 75)
        begin
            // no checksum field at all
        end
        else if (mode < 80)
        begin
            // leading 1 pushes the hex value past a byte
            put_byte(CHAR_STAR);
            put_byte(hex_ascii(4'd1, 1'b0));
            seal_frame(8'h00, 1'($urandom_range(0, 1)));
            frame_q.delete(frame_q.size() - 3);
        end
        else if (mode < 85)
        begin
            put_byte(CHAR_STAR);
            if ($urandom_range(0, 1) == 1)
                put_byte(hex_ascii(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
        end
        else if (mode < 90)
        begin
            // drop the line without a terminator
            send_frame();
            return;
        end
        else
            repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(0, 255)));
        pick = $urandom_range(0, 19);
        if (pick == 0)
            put_byte(CHAR_DOLLAR);
        else if (pick < 10)
            put_byte(CHAR_LF);
        else
            put_byte(CHAR_CR);
        // idle noise between sentences
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(0, 255)));
        send_frame();
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        rx_byte    = '0;
        bytes_sent = 0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // ---------------- directed sentences ----------------
        // every head kind, both terminators, both hex cases
        add_text("$GPRMC,1");
        seal_frame(8'h00, 1'b0);
        put_byte(CHAR_CR);
        send_frame();
        add_text("$GNRMC");
        seal_frame(8'h00, 1'b1);
        put_byte(CHAR_LF);
        send_frame();
        add_text("$GPGGA,x");
        seal_frame(8'h00, 1'b1);
        put_byte(CHAR_CR);
        send_frame();
        add_text("$GNGGA");
        seal_frame(8'h00, 1'b0);
        put_byte(CHAR_LF);
        send_frame();
        add_text("$GPGSV,3");
        seal_frame(8'h00, 1'b0);
        put_byte(CHAR_CR);
        send_frame();
        // unknown head, and a head cut short by the star
        add_text("$GPXYZ");
        seal_frame(8'h00, 1'b0);
        put_byte(CHAR_CR);
        send_frame();
        add_text("$GPRM");
        seal_frame(8'h00, 1'b0);
        put_byte(CHAR_CR);
        send_frame();
        // empty text with a zero sum, and a bare dollar
        add_text("$");
        seal_frame(8'h00, 1'b0);
        put_byte(CHAR_CR);
        add_text("$");
        put_byte(CHAR_LF);
        send_frame();
        // no star, wrong sum, hex value above a byte; the receiver holds
        // off meanwhile so the second terminator stalls the input
        hold_req = 1'b1;
        add_text("$GPRMC,abc");
        put_byte(CHAR_LF);
        add_text("$GPGGA,1");
        seal_frame(8'h5A, 1'b0);
        put_byte(CHAR_CR);
        add_text("$AA*100");
        put_byte(CHAR_CR);
        send_frame();
        // star with no digits: wrong against a sum, right against zero
        add_text("$GPGGA*");
        put_byte(CHAR_CR);
        add_text("$*");
        put_byte(CHAR_LF);
        send_frame();
        // single digit closed by a comma, then later stars outside the sum
        add_text("$pq*1,");
        put_byte(CHAR_CR);
        add_text("$AB");
        seal_frame(8'h00, 1'b0);
        add_text("*77");
        put_byte(CHAR_CR);
        send_frame();
        // high bytes enter the sum unsigned
        add_text("$");
        put_byte(8'hFF);
        put_byte(8'h80);
        put_byte(8'h7F);
        seal_frame(8'h00, 1'b1);
        put_byte(CHAR_CR);
        send_frame();
        // zero byte ends the text; the star after it does not count
        add_text("$GP");
        put_byte(CHAR_NUL);
        add_text("RMC");
        seal_frame(8'h00, 1'b0);
        put_byte(CHAR_LF);
        send_frame();
        // restart by a second dollar, then terminators and noise while idle
        add_text("$GPRM$GPGGA,7");
        seal_frame(8'h00, 1'b0);
        put_byte(CHAR_CR);
        put_byte(CHAR_CR);
        put_byte(CHAR_LF);
        put_byte(CHAR_NUL);
        put_byte(8'hFF);
        send_frame();

        // hold off the input until every report is back
        release_input();
        while (board.due_reports.size() != 0)
            @(posedge clk);

        // ---------------- random traffic ----------------
        frame_idx = 0;
        long_sel  = 0;
        while (bytes_sent < TARGET_BYTES || long_sel < 3)
        begin
            if (frame_idx % 2 == 1 && long_sel < 3)
            begin
                // buffer edges: last length that fits, exactly full then a
                // fresh dollar, and one byte past the end
                case (long_sel)
                    0:       long_frame(FRAME_CAP - 1, CHAR_CR, 1'b1);
                    1:       long_frame(FRAME_CAP, CHAR_CR, 1'b0);
                    default: long_frame(FRAME_CAP + 1, CHAR_LF, 1'b1);
                endcase
                long_sel++;
            end
            else
                random_frame();
            frame_idx++;
        end

        // closing stretch at full rate on both sides
        idle_on = 1'b0;
        repeat (4) random_frame();
        release_input();

        while (board.due_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d bytes, checked %0d reports (%0d dropped overflows), %0d errors",
                 bytes_sent, board.checked, board.drops, board.errors);
        $display("Reports by status ok/nosum/bad %0d/%0d/%0d, kind other/rmc/gga/gsv %0d/%0d/%0d/%0d",
                 board.status_hits[0], board.status_hits[1], board.status_hits[2],
                 board.kind_hits[0], board.kind_hits[1], board.kind_hits[2], board.kind_hits[3]);
        if (board.errors == 0 && board.due_reports.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/nsfc_pkg.sv
hw/rtl/nsfc_in_stage.sv
hw/rtl/nsfc_frame_core.sv
hw/rtl/nsfc_out_stage.sv
hw/rtl/nmea_sentence_framer_checker.sv
tb/tb_top.sv
